FILE: rtl/idll_pkg.sv
// ----------------------------------------------------------------------------
// idll_pkg
// Shared types and codes for the indexed doubly linked list block.
// ----------------------------------------------------------------------------
package idll_pkg;

	// command kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FREE_SLOT = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// command word
	typedef struct packed {
		logic        kind;
		logic [7:0]  slot_index;
		logic [63:0] value_in;
	} cmd_word_t;

	// result word
	typedef struct packed {
		status_t     status;
		logic [63:0] value_out;
		logic [7:0]  taken_slot;
		logic [7:0]  head_slot;
		logic [7:0]  tail_slot;
		logic [7:0]  live_count;
	} res_word_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic read;
		logic check;
		logic link;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic reject;
	} sts_t;

endpackage

FILE: rtl/indexed_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// Doubly linked list in a fixed node array with a free list of slots.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the link memories, with
// busy high, until every slot is written. Then a command word is taken when
// start is high and busy is low. A successful insert or pop keeps busy high
// through the read, check and link states (a memory read, then two link
// writes, set by the single write port of each link memory); a rejected
// command returns to idle after the check state. The result word is on result
// for exactly one cycle with done high, on the cycle after the last step, and
// must be taken then: there is no way to hold it. busy is already low in
// that cycle, so the next command may be issued alongside it.
module indexed_doubly_linked_list
	import idll_pkg::*;
#(
	parameter int SLOTS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  cmd_word_t cmd,
	output logic      done,
	output res_word_t result
);

	ctl_t ctl;
	sts_t sts;

	idll_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	idll_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule

FILE: rtl/idll_ctrl.sv
// ----------------------------------------------------------------------------
// idll_ctrl
// Sequencer: clearing pass after reset, then read, check and link phases.
// ----------------------------------------------------------------------------
module idll_ctrl
	import idll_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_CHECK,
		S_LINK
	} state_t;

	state_t state_q;
	logic   busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_READ;
						busy_q  <= 1'b1;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (sts.reject) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy      = busy_q;
	assign ctl.clear = (state_q == S_CLEAR);
	assign ctl.load  = (state_q == S_IDLE) && start && !busy_q;
	assign ctl.read  = (state_q == S_READ);
	assign ctl.check = (state_q == S_CHECK);
	assign ctl.link  = (state_q == S_LINK);

endmodule

FILE: rtl/idll_datapath.sv
// ----------------------------------------------------------------------------
// idll_datapath
// Node memories, free list head, list shadows and result register.
// ----------------------------------------------------------------------------
module idll_datapath
	import idll_pkg::*;
#(
	parameter int SLOTS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctl_t      ctl,
	input  cmd_word_t cmd,
	output sts_t      sts,
	output logic      done,
	output res_word_t result
);

	localparam int IW = $clog2(SLOTS);

	// node memories
	logic [63:0]   data_mem [SLOTS];
	logic [IW-1:0] next_mem [SLOTS];
	logic [IW-1:0] prev_mem [SLOTS];
	logic          live_mem [SLOTS];

	// command registers
	logic          kind_q;
	logic [7:0]    idx_q;
	logic [63:0]   val_q;

	// list state
	logic [IW-1:0] free_head_q;
	logic [IW-1:0] count_q;
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [IW-1:0] clr_q;

	// registered read data
	logic [63:0]   rd_data_q;
	logic [IW-1:0] rd_nxt_a_q;
	logic [IW-1:0] rd_nxt_f_q;
	logic [IW-1:0] rd_prv_q;
	logic          rd_live_q;

	logic          done_q;
	res_word_t     res_q;

	logic [IW-1:0] slot_w;
	logic          in_range;
	logic          reject;
	status_t       reject_code;
	logic          wr_ok;

	logic          nx_we;
	logic [IW-1:0] nx_addr;
	logic [IW-1:0] nx_wdata;
	logic          pv_we;
	logic [IW-1:0] pv_addr;
	logic [IW-1:0] pv_wdata;
	logic          lv_we;
	logic [IW-1:0] lv_addr;
	logic          lv_wdata;
	logic          dt_we;

	logic [IW-1:0] head_nx;
	logic [IW-1:0] tail_nx;
	logic [IW-1:0] count_nx;
	logic [IW-1:0] free_nx;

	assign slot_w   = IW'(idx_q);
	assign in_range = (32'(idx_q) < SLOTS);
	assign wr_ok    = ctl.check && !reject;

	always_comb begin
		reject      = 1'b0;
		reject_code = ST_OK;
		if (kind_q == KIND_INSERT) begin
			if (!in_range || (idx_q != 8'd0 && !rd_live_q)) begin
				reject      = 1'b1;
				reject_code = ST_BAD_INDEX;
			end else if (free_head_q == '0) begin
				reject      = 1'b1;
				reject_code = ST_FULL;
			end
		end else begin
			if (!in_range || idx_q == 8'd0) begin
				reject      = 1'b1;
				reject_code = ST_BAD_INDEX;
			end else if (!rd_live_q) begin
				reject      = 1'b1;
				reject_code = ST_FREE_SLOT;
			end
		end
	end

	// next link write port
	always_comb begin
		nx_we    = 1'b0;
		nx_addr  = '0;
		nx_wdata = '0;
		if (ctl.clear) begin
			nx_we    = 1'b1;
			nx_addr  = clr_q;
			nx_wdata = (clr_q == '0 || clr_q == IW'(SLOTS - 1)) ? '0 : clr_q + 1'b1;
		end else if (wr_ok) begin
			nx_we = 1'b1;
			if (kind_q == KIND_INSERT) begin
				nx_addr  = free_head_q;
				nx_wdata = rd_nxt_a_q;
			end else begin
				// bypass the victim
				nx_addr  = rd_prv_q;
				nx_wdata = rd_nxt_a_q;
			end
		end else if (ctl.link) begin
			nx_we    = 1'b1;
			nx_addr  = slot_w;
			nx_wdata = free_head_q;
		end
	end

	// prev link write port
	always_comb begin
		pv_we    = 1'b0;
		pv_addr  = '0;
		pv_wdata = '0;
		if (ctl.clear) begin
			pv_we   = 1'b1;
			pv_addr = clr_q;
		end else if (wr_ok) begin
			pv_we = 1'b1;
			if (kind_q == KIND_INSERT) begin
				pv_addr  = free_head_q;
				pv_wdata = slot_w;
			end else begin
				pv_addr  = rd_nxt_a_q;
				pv_wdata = rd_prv_q;
			end
		end else if (ctl.link) begin
			pv_we = 1'b1;
			if (kind_q == KIND_INSERT) begin
				pv_addr  = rd_nxt_a_q;
				pv_wdata = free_head_q;
			end else begin
				pv_addr  = slot_w;
				pv_wdata = '0;
			end
		end
	end

	// live flag write port
	always_comb begin
		lv_we    = 1'b0;
		lv_addr  = '0;
		lv_wdata = 1'b0;
		if (ctl.clear) begin
			lv_we    = 1'b1;
			lv_addr  = clr_q;
			lv_wdata = (clr_q == '0);
		end else if (wr_ok) begin
			lv_we = 1'b1;
			if (kind_q == KIND_INSERT) begin
				lv_addr  = free_head_q;
				lv_wdata = 1'b1;
			end else begin
				lv_addr  = slot_w;
				lv_wdata = 1'b0;
			end
		end
	end

	assign dt_we = wr_ok && (kind_q == KIND_INSERT);

	always_ff @(posedge clk) begin
		if (nx_we) begin
			next_mem[nx_addr] <= nx_wdata;
		end
		if (ctl.read) begin
			rd_nxt_a_q <= next_mem[slot_w];
			rd_nxt_f_q <= next_mem[free_head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pv_we) begin
			prev_mem[pv_addr] <= pv_wdata;
		end
		if (ctl.read) begin
			rd_prv_q <= prev_mem[slot_w];
		end
	end

	always_ff @(posedge clk) begin
		if (lv_we) begin
			live_mem[lv_addr] <= lv_wdata;
		end
		if (ctl.read) begin
			rd_live_q <= live_mem[slot_w];
		end
	end

	// data of a free slot is never returned, so it needs no clearing
	always_ff @(posedge clk) begin
		if (dt_we) begin
			data_mem[free_head_q] <= val_q;
		end
		if (ctl.read) begin
			rd_data_q <= data_mem[slot_w];
		end
	end

	// list state after a successful link phase
	always_comb begin
		head_nx = head_q;
		tail_nx = tail_q;
		if (kind_q == KIND_INSERT) begin
			free_nx  = rd_nxt_f_q;
			count_nx = count_q + 1'b1;
			if (slot_w == '0) begin
				head_nx = free_head_q;
			end
			if (rd_nxt_a_q == '0) begin
				tail_nx = free_head_q;
			end
		end else begin
			free_nx  = slot_w;
			count_nx = count_q - 1'b1;
			if (rd_prv_q == '0) begin
				head_nx = rd_nxt_a_q;
			end
			if (rd_nxt_a_q == '0) begin
				tail_nx = rd_prv_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= IW'(1);
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			clr_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (ctl.check && reject) || ctl.link;
			if (ctl.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctl.link) begin
				free_head_q <= free_nx;
				count_q     <= count_nx;
				head_q      <= head_nx;
				tail_q      <= tail_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kind_q <= cmd.kind;
			idx_q  <= cmd.slot_index;
			val_q  <= cmd.value_in;
		end
		if (ctl.check && reject) begin
			res_q.status     <= reject_code;
			res_q.value_out  <= '0;
			res_q.taken_slot <= '0;
			res_q.head_slot  <= 8'(head_q);
			res_q.tail_slot  <= 8'(tail_q);
			res_q.live_count <= 8'(count_q);
		end else if (ctl.link) begin
			res_q.status     <= ST_OK;
			res_q.value_out  <= (kind_q == KIND_POP) ? rd_data_q : '0;
			res_q.taken_slot <= (kind_q == KIND_POP) ? 8'(slot_w) : 8'(free_head_q);
			res_q.head_slot  <= 8'(head_nx);
			res_q.tail_slot  <= 8'(tail_nx);
			res_q.live_count <= 8'(count_nx);
		end
	end

	assign sts.clr_last = (clr_q == IW'(SLOTS - 1));
	assign sts.reject   = reject;
	assign done         = done_q;
	assign result       = res_q;

endmodule
